[sv/shape_table_pixel_coverage_top_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef SHAPE_TABLE_PIXEL_COVERAGE_TOP_MACROS_SVH
`define SHAPE_TABLE_PIXEL_COVERAGE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define STPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never holds outside reset.
`define STPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STPC_ASSERT(label, clk, rst_n, prop, msg)
`define STPC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[sv/stpc_pkg.sv]
`timescale 1ns / 1ps

package stpc_pkg;

    // Field widths.
    localparam int POS_W  = 12;
    localparam int SIZE_W = 11;
    localparam int PIX_W  = 10;
    localparam int OP_W   = 3;
    localparam int COLOR_W = 8;

    // Stored entry widths: origin, origin, one or two sizes.
    localparam int SHORT_W = 2 * POS_W + SIZE_W;
    localparam int LONG_W  = 2 * POS_W + 2 * SIZE_W;

    // Shared multiplier geometry.
    localparam int MUL_W  = 2 * POS_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RSQ_W  = 2 * SIZE_W;

    localparam int MAX_SHAPES_DEF = 64;

    // Pixels at or beyond this row or column are black.
    localparam int FRAME_WIDTH = 1024;
    localparam int FRAME_CMP_W = 13;

    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_ADD_SQU = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_REC = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_CIR = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_ELL = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    // Table codes match the low bits of the add opcodes.
    typedef logic [1:0] t_tab;
    localparam t_tab TAB_SQU = 2'd0;
    localparam t_tab TAB_REC = 2'd1;
    localparam t_tab TAB_CIR = 2'd2;
    localparam t_tab TAB_ELL = 2'd3;

    // Status returned by the entry evaluator.
    typedef struct packed {
        logic done;
        logic hit;
    } t_eval_sts;

endpackage

[sv/stpc_ram.sv]
`timescale 1ns / 1ps

module stpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/stpc_eval.sv]
`timescale 1ns / 1ps
`include "shape_table_pixel_coverage_top_macros.svh"

module stpc_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  stpc_pkg::t_tab                      i_kind,
    input  logic signed [stpc_pkg::POS_W-1:0]   i_px,
    input  logic signed [stpc_pkg::POS_W-1:0]   i_py,
    input  logic [stpc_pkg::SIZE_W-1:0]         i_sa,
    input  logic [stpc_pkg::SIZE_W-1:0]         i_sb,
    input  logic [stpc_pkg::PIX_W-1:0]          i_row,
    input  logic [stpc_pkg::PIX_W-1:0]          i_col,
    output stpc_pkg::t_eval_sts                 o_sts
);

    import stpc_pkg::*;

    localparam int DW    = POS_W + 1;
    localparam int BOX_W = POS_W + 2;

    // Step codes, named after the product issued in that step.
    localparam logic [2:0] SP_DX  = 3'd0;
    localparam logic [2:0] SP_DY  = 3'd1;
    localparam logic [2:0] SP_RX  = 3'd2;
    localparam logic [2:0] SP_RY  = 3'd3;
    localparam logic [2:0] SP_T1  = 3'd4;
    localparam logic [2:0] SP_T2  = 3'd5;
    localparam logic [2:0] SP_RR  = 3'd6;
    localparam logic [2:0] SP_CMP = 3'd7;

    logic                r_busy;
    logic [2:0]          r_step;
    logic                w_active;
    logic [2:0]          w_step;
    logic [2:0]          w_last;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;
    logic [POS_W-1:0]    w_adx;
    logic [POS_W-1:0]    w_ady;
    logic [MUL_W-1:0]    w_ma;
    logic [MUL_W-1:0]    w_mb;
    logic [PROD_W-1:0]   r_prod;
    logic [MUL_W-1:0]    r_sq_dx;
    logic [MUL_W-1:0]    r_sq_dy;
    logic [RSQ_W-1:0]    r_rx2;
    logic [RSQ_W-1:0]    r_ry2;
    logic [PROD_W-1:0]   r_t1;
    logic [PROD_W-1:0]   r_t2;
    logic [SIZE_W-1:0]   w_h;
    logic signed [BOX_W-1:0] w_px_e;
    logic signed [BOX_W-1:0] w_py_e;
    logic signed [BOX_W-1:0] w_pxw;
    logic signed [BOX_W-1:0] w_pyh;
    logic signed [BOX_W-1:0] w_row_e;
    logic signed [BOX_W-1:0] w_col_e;
    logic                w_box_hit;
    logic                w_cir_hit;
    logic                w_ell_hit;
    logic                w_hit;

    // The first step runs in the start cycle itself, so a box test finishes at once.
    assign w_active = i_start | r_busy;
    assign w_step   = i_start ? SP_DX : r_step;

    always_comb begin
        case (i_kind)
            TAB_ELL: w_last = SP_CMP;
            TAB_CIR: w_last = SP_RY;
            default: w_last = SP_DX;
        endcase
    end

    assign w_dx  = DW'(i_px) - $signed({{(DW - PIX_W){1'b0}}, i_col});
    assign w_dy  = DW'(i_py) - $signed({{(DW - PIX_W){1'b0}}, i_row});
    assign w_adx = w_dx[DW-1] ? POS_W'(-w_dx) : w_dx[POS_W-1:0];
    assign w_ady = w_dy[DW-1] ? POS_W'(-w_dy) : w_dy[POS_W-1:0];

    always_comb begin
        case (w_step)
            SP_DX: begin
                w_ma = MUL_W'(w_adx);
                w_mb = MUL_W'(w_adx);
            end
            SP_DY: begin
                w_ma = MUL_W'(w_ady);
                w_mb = MUL_W'(w_ady);
            end
            SP_RX: begin
                w_ma = MUL_W'(i_sa);
                w_mb = MUL_W'(i_sa);
            end
            SP_RY: begin
                w_ma = MUL_W'(i_sb);
                w_mb = MUL_W'(i_sb);
            end
            SP_T1: begin
                w_ma = r_sq_dx;
                w_mb = r_prod[MUL_W-1:0];
            end
            SP_T2: begin
                w_ma = r_sq_dy;
                w_mb = MUL_W'(r_rx2);
            end
            SP_RR: begin
                w_ma = MUL_W'(r_rx2);
                w_mb = MUL_W'(r_ry2);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_active) begin
            r_prod <= w_ma * w_mb;
            case (w_step)
                SP_DY:   r_sq_dx <= r_prod[MUL_W-1:0];
                SP_RX:   r_sq_dy <= r_prod[MUL_W-1:0];
                SP_RY:   r_rx2   <= r_prod[RSQ_W-1:0];
                SP_T1:   r_ry2   <= r_prod[RSQ_W-1:0];
                SP_T2:   r_t1    <= r_prod;
                SP_RR:   r_t2    <= r_prod;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= SP_DX;
        end else if (i_start) begin
            r_busy <= (w_step != w_last);
            r_step <= SP_DY;
        end else if (r_busy) begin
            if (w_step == w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    // Box test: both ends of each span count as inside.
    assign w_h     = (i_kind == TAB_SQU) ? i_sa : i_sb;
    assign w_px_e  = BOX_W'(i_px);
    assign w_py_e  = BOX_W'(i_py);
    assign w_pxw   = w_px_e + $signed({{(BOX_W - SIZE_W){1'b0}}, i_sa});
    assign w_pyh   = w_py_e + $signed({{(BOX_W - SIZE_W){1'b0}}, w_h});
    assign w_row_e = $signed({{(BOX_W - PIX_W){1'b0}}, i_row});
    assign w_col_e = $signed({{(BOX_W - PIX_W){1'b0}}, i_col});
    assign w_box_hit = (w_row_e >= w_py_e) && (w_row_e <= w_pyh) &&
                       (w_col_e >= w_px_e) && (w_col_e <= w_pxw);

    // At the circle's last step the product register holds the squared radius.
    assign w_cir_hit = (PROD_W'(r_sq_dx) + PROD_W'(r_sq_dy)) <= r_prod;

    // At the ellipse's last step the product register holds rx^2 * ry^2.
    assign w_ell_hit = (r_rx2 != '0) && (r_ry2 != '0) && ((r_t1 + r_t2) <= r_prod);

    always_comb begin
        case (i_kind)
            TAB_ELL: w_hit = w_ell_hit;
            TAB_CIR: w_hit = w_cir_hit;
            default: w_hit = w_box_hit;
        endcase
    end

    assign o_sts.done = w_active && (w_step == w_last);
    assign o_sts.hit  = w_hit;

    `STPC_ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_start && r_busy, "eval started while busy")
    `STPC_ASSERT(a_ell_zero_radius, i_clk, i_rst_n, (o_sts.done && o_sts.hit && i_kind == TAB_ELL) |-> (i_sa != '0 && i_sb != '0), "ellipse with zero radius reported a hit")
    `STPC_ASSERT(a_ell_multi_cycle, i_clk, i_rst_n, (o_sts.done && i_kind == TAB_ELL) |-> r_busy, "ellipse test finished in its start cycle")

endmodule

[sv/shape_table_pixel_coverage_top.sv]
`timescale 1ns / 1ps
// An add is taken in the idle state, written in dispatch unless its table is full, and its
// result is loaded into the output register from the done state once that register is free.
// A query passes dispatch, reads each stored ellipse, circle, rectangle and square in a scan
// step and tests it with the evaluator's one shared multiplier, closes each table in a scan
// step and stops at the first hit. No new item is taken until the result has been loaded.
// Reset (synchronous, active low) empties all four tables and the output register.
`include "shape_table_pixel_coverage_top_macros.svh"

module shape_table_pixel_coverage_top #(
    parameter int MAX_SHAPES = stpc_pkg::MAX_SHAPES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [stpc_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [stpc_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [stpc_pkg::POS_W-1:0]   i_pos_y,
    input  logic [stpc_pkg::SIZE_W-1:0]         i_size_a,
    input  logic [stpc_pkg::SIZE_W-1:0]         i_size_b,
    input  logic [stpc_pkg::PIX_W-1:0]          i_pixel_row,
    input  logic [stpc_pkg::PIX_W-1:0]          i_pixel_col,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [stpc_pkg::COLOR_W-1:0]        o_red,
    output logic [stpc_pkg::COLOR_W-1:0]        o_green,
    output logic [stpc_pkg::COLOR_W-1:0]        o_blue,
    output logic                                o_table_full
);

    import stpc_pkg::*;

    // The count must hold MAX_SHAPES itself; the address only needs the entries.
    localparam int CW = $clog2(MAX_SHAPES + 1);
    localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam logic [CW-1:0] LP_MAX = CW'(MAX_SHAPES);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_START    = 3'd3;
    localparam logic [2:0] S_WAIT     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // Colors as {red, green, blue} on/off bits.
    localparam logic [2:0] RGB_MAGENTA = 3'b101;
    localparam logic [2:0] RGB_BLUE    = 3'b001;
    localparam logic [2:0] RGB_GREEN   = 3'b010;
    localparam logic [2:0] RGB_RED     = 3'b100;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    t_tab                r_tab;
    t_tab                n_tab;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       n_idx;
    logic [CW-1:0]       r_cnt [4];
    logic [CW-1:0]       n_cnt [4];
    logic [2:0]          r_res_rgb;
    logic [2:0]          n_res_rgb;
    logic                r_res_full;
    logic                n_res_full;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [2:0]          r_out_rgb;
    logic                r_out_full;

    // Captured input item.
    logic [OP_W-1:0]     r_op;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic [SIZE_W-1:0]   r_sa;
    logic [SIZE_W-1:0]   r_sb;
    logic [PIX_W-1:0]    r_row;
    logic [PIX_W-1:0]    r_col;

    logic                w_in_xfer;
    logic                w_load;
    logic                w_start;
    logic [3:0]          w_we;
    logic [3:0]          w_re;
    t_tab                w_tab_sel;
    logic [CW-1:0]       w_cnt_sel;
    logic                w_in_frame;
    logic [SHORT_W-1:0]  w_short_wdata;
    logic [LONG_W-1:0]   w_long_wdata;
    logic [SHORT_W-1:0]  w_squ_rdata;
    logic [LONG_W-1:0]   w_rec_rdata;
    logic [SHORT_W-1:0]  w_cir_rdata;
    logic [LONG_W-1:0]   w_ell_rdata;
    logic signed [POS_W-1:0] w_e_px;
    logic signed [POS_W-1:0] w_e_py;
    logic [SIZE_W-1:0]   w_e_sa;
    logic [SIZE_W-1:0]   w_e_sb;
    t_eval_sts           w_sts;
    logic [2:0]          w_hit_rgb;

    // The input side is open only in the idle state and outside reset; a finished result
    // may still be waiting in the output register while the next item is taken.
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op  <= i_opcode;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_sa  <= i_size_a;
            r_sb  <= i_size_b;
            r_row <= i_pixel_row;
            r_col <= i_pixel_col;
        end
    end

    // During dispatch the table is named by the add opcode, during a walk by r_tab.
    assign w_tab_sel = (r_state == S_DISPATCH) ? r_op[1:0] : r_tab;
    assign w_cnt_sel = r_cnt[w_tab_sel];

    assign w_in_frame = (FRAME_CMP_W'(r_row) < FRAME_CMP_W'(FRAME_WIDTH)) &&
                        (FRAME_CMP_W'(r_col) < FRAME_CMP_W'(FRAME_WIDTH));

    always_comb begin
        case (r_tab)
            TAB_ELL: w_hit_rgb = RGB_MAGENTA;
            TAB_CIR: w_hit_rgb = RGB_BLUE;
            TAB_REC: w_hit_rgb = RGB_GREEN;
            default: w_hit_rgb = RGB_RED;
        endcase
    end

    // Main sequencer. A query walks the ellipse, circle, rectangle and square tables in
    // that order, one entry at a time, and stops at the first covering shape.
    always_comb begin
        n_state    = r_state;
        n_tab      = r_tab;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_res_rgb  = r_res_rgb;
        n_res_full = r_res_full;
        w_we       = '0;
        w_re       = '0;
        w_start    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_rgb  = '0;
                n_res_full = 1'b0;
                n_state    = S_DONE;
                case (r_op)
                    OP_ADD_SQU, OP_ADD_REC, OP_ADD_CIR, OP_ADD_ELL: begin
                        if (w_cnt_sel >= LP_MAX) begin
                            n_res_full = 1'b1;
                        end else begin
                            w_we[w_tab_sel]  = 1'b1;
                            n_cnt[w_tab_sel] = w_cnt_sel + CW'(1);
                        end
                    end
                    OP_QUERY: begin
                        if (w_in_frame) begin
                            n_tab   = TAB_ELL;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (r_idx < w_cnt_sel) begin
                    w_re[r_tab] = 1'b1;
                    n_state     = S_START;
                end else if (r_tab == TAB_SQU) begin
                    n_state = S_DONE;
                end else begin
                    n_tab = r_tab - 2'd1;
                    n_idx = '0;
                end
            end
            S_START, S_WAIT: begin
                w_start = (r_state == S_START);
                if (w_sts.done) begin
                    if (w_sts.hit) begin
                        n_res_rgb = w_hit_rgb;
                        n_state   = S_DONE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_SCAN;
                    end
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tab       <= TAB_ELL;
            r_idx       <= '0;
            r_cnt       <= '{default: '0};
            r_res_rgb   <= '0;
            r_res_full  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tab       <= n_tab;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_res_rgb   <= n_res_rgb;
            r_res_full  <= n_res_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_rgb  <= r_res_rgb;
            r_out_full <= r_res_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_out_rgb[2] ? COLOR_MAX : '0;
    assign o_green      = r_out_rgb[1] ? COLOR_MAX : '0;
    assign o_blue       = r_out_rgb[0] ? COLOR_MAX : '0;
    assign o_table_full = r_out_full;

    // Shape tables. Squares and circles keep one size, rectangles and ellipses two.
    assign w_short_wdata = {r_px, r_py, r_sa};
    assign w_long_wdata  = {r_px, r_py, r_sa, r_sb};

    stpc_ram #(.WIDTH(SHORT_W), .DEPTH(MAX_SHAPES), .AW(AW)) u_squ_ram (
        .i_clk   (i_clk),
        .i_we    (w_we[TAB_SQU]),
        .i_waddr (w_cnt_sel[AW-1:0]),
        .i_wdata (w_short_wdata),
        .i_re    (w_re[TAB_SQU]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_squ_rdata)
    );

    stpc_ram #(.WIDTH(LONG_W), .DEPTH(MAX_SHAPES), .AW(AW)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we[TAB_REC]),
        .i_waddr (w_cnt_sel[AW-1:0]),
        .i_wdata (w_long_wdata),
        .i_re    (w_re[TAB_REC]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rec_rdata)
    );

    stpc_ram #(.WIDTH(SHORT_W), .DEPTH(MAX_SHAPES), .AW(AW)) u_cir_ram (
        .i_clk   (i_clk),
        .i_we    (w_we[TAB_CIR]),
        .i_waddr (w_cnt_sel[AW-1:0]),
        .i_wdata (w_short_wdata),
        .i_re    (w_re[TAB_CIR]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_cir_rdata)
    );

    stpc_ram #(.WIDTH(LONG_W), .DEPTH(MAX_SHAPES), .AW(AW)) u_ell_ram (
        .i_clk   (i_clk),
        .i_we    (w_we[TAB_ELL]),
        .i_waddr (w_cnt_sel[AW-1:0]),
        .i_wdata (w_long_wdata),
        .i_re    (w_re[TAB_ELL]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_ell_rdata)
    );

    // The read data stays put until the next read, so it feeds the evaluator for the
    // whole test of one entry.
    always_comb begin
        case (r_tab)
            TAB_SQU: begin
                w_e_px = w_squ_rdata[SHORT_W-1 -: POS_W];
                w_e_py = w_squ_rdata[SIZE_W +: POS_W];
                w_e_sa = w_squ_rdata[SIZE_W-1:0];
                w_e_sb = w_squ_rdata[SIZE_W-1:0];
            end
            TAB_CIR: begin
                w_e_px = w_cir_rdata[SHORT_W-1 -: POS_W];
                w_e_py = w_cir_rdata[SIZE_W +: POS_W];
                w_e_sa = w_cir_rdata[SIZE_W-1:0];
                w_e_sb = w_cir_rdata[SIZE_W-1:0];
            end
            TAB_REC: begin
                w_e_px = w_rec_rdata[LONG_W-1 -: POS_W];
                w_e_py = w_rec_rdata[2*SIZE_W +: POS_W];
                w_e_sa = w_rec_rdata[SIZE_W +: SIZE_W];
                w_e_sb = w_rec_rdata[SIZE_W-1:0];
            end
            default: begin
                w_e_px = w_ell_rdata[LONG_W-1 -: POS_W];
                w_e_py = w_ell_rdata[2*SIZE_W +: POS_W];
                w_e_sa = w_ell_rdata[SIZE_W +: SIZE_W];
                w_e_sb = w_ell_rdata[SIZE_W-1:0];
            end
        endcase
    end

    stpc_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_kind  (r_tab),
        .i_px    (w_e_px),
        .i_py    (w_e_py),
        .i_sa    (w_e_sa),
        .i_sb    (w_e_sb),
        .i_row   (r_row),
        .i_col   (r_col),
        .o_sts   (w_sts)
    );

    `STPC_ASSERT(a_count_bound, i_clk, i_rst_n,
        (r_cnt[0] <= LP_MAX) && (r_cnt[1] <= LP_MAX) &&
        (r_cnt[2] <= LP_MAX) && (r_cnt[3] <= LP_MAX),
        "table count above capacity")
    `STPC_ASSERT_NEVER(a_done_outside_walk, i_clk, i_rst_n,
        w_sts.done && !(r_state == S_START || r_state == S_WAIT),
        "evaluator finished outside a walk")
    `STPC_ASSERT(a_query_not_full, i_clk, i_rst_n,
        (r_state == S_DISPATCH && r_op == OP_QUERY) |=> !r_res_full,
        "query flagged a full table")

endmodule

[tb/shape_table_pixel_coverage_top_tb.sv]
`timescale 1ns / 1ps

module shape_table_pixel_coverage_top_tb;
    import stpc_pkg::*;

    localparam int SHAPE_CAP = MAX_SHAPES_DEF;
    localparam int POS_MIN  = -(1 << (POS_W - 1));
    localparam int POS_MAX  = (1 << (POS_W - 1)) - 1;
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int PIX_MAX  = (1 << PIX_W) - 1;
    localparam int RANDOM_ITEMS = 500;

    // Opcode values above the query opcode decode to nothing.
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_QUERY + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [OP_W-1:0] ADD_OPS [4] = '{OP_ADD_SQU, OP_ADD_REC, OP_ADD_CIR, OP_ADD_ELL};

    // Even if every item were as slow as a query that misses everything in full tables, plus
    // the longest gaps and stalls, the run would stay far below this.
    localparam longint RUN_LIMIT_NS = 64'd40_000_000;

    typedef struct {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [SIZE_W-1:0]       sa;
        logic [SIZE_W-1:0]       sb;
    } t_shape_entry;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               full;
    } t_pixel_result;

    // Keeps a private copy of the four shape tables, works out the color (or the
    // table-full flag) each accepted transfer must produce, and checks the outputs in order.
    class t_scene_scoreboard;
        t_shape_entry  shapes [4][SHAPE_CAP];
        int unsigned   fill [4];
        t_pixel_result awaited [$];
        int unsigned   bad_count;
        int unsigned   dropped_adds;
        int unsigned   queries;
        int unsigned   n_magenta, n_blue, n_green, n_red, n_black;

        function bit covers_box(t_shape_entry e, int w, int h, int row, int col);
            int x0 = e.px;
            int y0 = e.py;
            return row >= y0 && row <= y0 + h && col >= x0 && col <= x0 + w;
        endfunction

        function bit covers_disc(t_shape_entry e, int row, int col);
            longint dx = int'(e.px) - col;
            longint dy = int'(e.py) - row;
            longint rad = e.sa;
            return dx * dx + dy * dy <= rad * rad;
        endfunction

        // Integer form of the ellipse test; a zero radius on either axis covers nothing.
        function bit covers_oval(t_shape_entry e, int row, int col);
            longint dx = int'(e.px) - col;
            longint dy = int'(e.py) - row;
            longint ax = e.sa;
            longint ay = e.sb;
            longint rx2 = ax * ax;
            longint ry2 = ay * ay;
            if (rx2 == 0 || ry2 == 0)
                return 1'b0;
            return dx * dx * ry2 + dy * dy * rx2 <= rx2 * ry2;
        endfunction

        function t_pixel_result shade(int row, int col);
            t_pixel_result res = '0;
            bit hit = 1'b0;
            queries++;
            if (row >= FRAME_WIDTH || col >= FRAME_WIDTH) begin
                n_black++;
                return res;
            end
            for (int k = 0; k < fill[TAB_ELL]; k++)
                hit |= covers_oval(shapes[TAB_ELL][k], row, col);
            if (hit) begin
                res.red  = COLOR_MAX;
                res.blue = COLOR_MAX;
                n_magenta++;
                return res;
            end
            for (int k = 0; k < fill[TAB_CIR]; k++)
                hit |= covers_disc(shapes[TAB_CIR][k], row, col);
            if (hit) begin
                res.blue = COLOR_MAX;
                n_blue++;
                return res;
            end
            for (int k = 0; k < fill[TAB_REC]; k++)
                hit |= covers_box(shapes[TAB_REC][k], shapes[TAB_REC][k].sa,
                                  shapes[TAB_REC][k].sb, row, col);
            if (hit) begin
                res.green = COLOR_MAX;
                n_green++;
                return res;
            end
            for (int k = 0; k < fill[TAB_SQU]; k++)
                hit |= covers_box(shapes[TAB_SQU][k], shapes[TAB_SQU][k].sa,
                                  shapes[TAB_SQU][k].sa, row, col);
            if (hit) begin
                res.red = COLOR_MAX;
                n_red++;
            end else
                n_black++;
            return res;
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic signed [POS_W-1:0] px,
                                logic signed [POS_W-1:0] py, logic [SIZE_W-1:0] sa,
                                logic [SIZE_W-1:0] sb, logic [PIX_W-1:0] row,
                                logic [PIX_W-1:0] col);
            t_pixel_result res = '0;
            t_tab tab = TAB_SQU;
            bit is_add = 1'b1;
            case (op)
                OP_ADD_SQU: tab = TAB_SQU;
                OP_ADD_REC: tab = TAB_REC;
                OP_ADD_CIR: tab = TAB_CIR;
                OP_ADD_ELL: tab = TAB_ELL;
                default:    is_add = 1'b0;
            endcase
            if (is_add) begin
                if (fill[tab] >= SHAPE_CAP) begin
                    res.full = 1'b1;
                    dropped_adds++;
                end else begin
                    shapes[tab][fill[tab]] = '{px, py, sa, sb};
                    fill[tab]++;
                end
            end else if (op == OP_QUERY)
                res = shade(row, col);
            awaited.push_back(res);
        endfunction

        function void check_pixel(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                  logic [COLOR_W-1:0] blue, logic full);
            t_pixel_result want;
            if (awaited.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("[%0t] result with nothing outstanding: %0d,%0d,%0d/%0b",
                             $realtime, red, green, blue, full);
                return;
            end
            want = awaited.pop_front();
            if (red !== want.red || green !== want.green || blue !== want.blue ||
                full !== want.full) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("[%0t] expected %0d,%0d,%0d/%0b got %0d,%0d,%0d/%0b",
                             $realtime, want.red, want.green, want.blue, want.full,
                             red, green, blue, full);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_opcode = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic [SIZE_W-1:0]       i_size_a = '0;
    logic [SIZE_W-1:0]       i_size_b = '0;
    logic [PIX_W-1:0]        i_pixel_row = '0;
    logic [PIX_W-1:0]        i_pixel_col = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [COLOR_W-1:0]      o_red;
    logic [COLOR_W-1:0]      o_green;
    logic [COLOR_W-1:0]      o_blue;
    logic                    o_table_full;

    t_scene_scoreboard board = new;

    // Both sides insert random gaps while this is set; it is cleared for quiet stretches.
    bit idling_on = 1'b1;
    int r_sink_hold = 0;

    shape_table_pixel_coverage_top #(
        .MAX_SHAPES(SHAPE_CAP)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_size_a    (i_size_a),
        .i_size_b    (i_size_b),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_table_full(o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: while idling is enabled, ready drops at random and stays low for a randomly drawn hold.
    always @(posedge i_clk) begin
        if (r_sink_hold > 0) begin
            r_sink_hold <= r_sink_hold - 1;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            r_sink_hold <= $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else
            i_out_ready <= 1'b1;
    end

    // Every result transfer is checked against the oldest outstanding prediction. Inputs
    // change only through nonblocking updates, so the values read here are the ones the
    // block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_pixel(o_red, o_green, o_blue, o_table_full);
    end

    // Presents one item, possibly after a short gap, and returns at the edge that
    // accepts it. Valid is only touched once per edge: either lowered for a gap or
    // raised with the new payload.
    task automatic send_item(input logic [OP_W-1:0] op, input int px, input int py,
                             input int sa, input int sb, input int row, input int col);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_pos_x     <= POS_W'(px);
        i_pos_y     <= POS_W'(py);
        i_size_a    <= SIZE_W'(sa);
        i_size_b    <= SIZE_W'(sb);
        i_pixel_row <= PIX_W'(row);
        i_pixel_col <= PIX_W'(col);
        do
            @(posedge i_clk);
        while (!o_in_ready);
        board.note_item(i_opcode, i_pos_x, i_pos_y, i_size_a, i_size_b,
                        i_pixel_row, i_pixel_col);
    endtask

    // Holds the input side quiet until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly small or medium shapes in and around the frame. A few are oversized, with
    // full-range sizes, but are parked on the far negative edge of one axis so that they
    // stay off the frame and do not paint every later query the same color.
    task automatic pick_shape(output int px, output int py, output int sa, output int sb);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            sa = $urandom_range(0, SIZE_MAX);
            sb = $urandom_range(0, SIZE_MAX);
            px = int'($urandom_range(0, POS_MAX - POS_MIN)) + POS_MIN;
            py = int'($urandom_range(0, POS_MAX - POS_MIN)) + POS_MIN;
            if ($urandom_range(0, 1) == 1)
                px = POS_MIN;
            else
                py = POS_MIN;
        end else begin
            px = int'($urandom_range(0, FRAME_WIDTH + 127)) - 64;
            py = int'($urandom_range(0, FRAME_WIDTH + 127)) - 64;
            if (kind < 25) begin
                sa = $urandom_range(0, 200);
                sb = $urandom_range(0, 200);
            end else begin
                sa = $urandom_range(0, 31);
                sb = $urandom_range(0, 31);
            end
        end
    endtask

    initial begin
        logic [OP_W-1:0] op;
        int px, py, sa, sb, row, col, pick, add_pct, h, r, c;
        t_tab tab;
        t_shape_entry e;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Empty tables give black.
        send_item(OP_QUERY, 0, 0, 0, 0, 0, 0);
        // Extreme square placed beyond the frame, then a one-pixel square.
        send_item(OP_ADD_SQU, POS_MAX, POS_MAX, SIZE_MAX, 0, PIX_MAX, PIX_MAX);
        send_item(OP_ADD_SQU, 5, 5, 0, SIZE_MAX, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 5, 5);
        send_item(OP_QUERY, 0, 0, 0, 0, 6, 5);
        // Extreme rectangle ending just before the frame, then a one-row rectangle whose
        // far corner is checked for inclusive edges.
        send_item(OP_ADD_REC, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX, 0, 0);
        send_item(OP_ADD_REC, 20, 30, 10, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 30, 30);
        send_item(OP_QUERY, 0, 0, 0, 0, 31, 20);
        // A zero-radius circle covers its center only.
        send_item(OP_ADD_CIR, 100, 100, 0, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 100, 100);
        send_item(OP_QUERY, 0, 0, 0, 0, 100, 101);
        send_item(OP_ADD_CIR, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX, 0, 0);
        // An ellipse with a zero radius on either axis never covers.
        send_item(OP_ADD_ELL, 200, 200, 0, 50, 0, 0);
        send_item(OP_ADD_ELL, 400, 200, 50, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 200, 200);
        // Ellipse edges on both axes, and one step past the edge.
        send_item(OP_ADD_ELL, 300, 300, 20, 10, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 310, 300);
        send_item(OP_QUERY, 0, 0, 0, 0, 300, 320);
        send_item(OP_QUERY, 0, 0, 0, 0, 311, 300);
        // A circle over the one-pixel square wins by priority; its rim counts as inside.
        send_item(OP_ADD_CIR, 5, 5, 3, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0, 0, 5, 5);
        send_item(OP_QUERY, 0, 0, 0, 0, 8, 5);
        send_item(OP_QUERY, POS_MIN, POS_MAX, SIZE_MAX, 0, PIX_MAX, PIX_MAX);
        // Unused opcodes return an all-zero result.
        send_item(OP_SPARE_LO, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX, PIX_MAX, PIX_MAX);
        send_item(OP_SPARE_HI, POS_MIN, POS_MAX, 0, SIZE_MAX, 0, PIX_MAX);
        drain_results();

        // Random part. The middle stretch leans on adds so the tables fill up, there is
        // one quiet window in the middle, and the tail runs without gaps on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = (n < 150 || n >= 200) && n < 420;
            if (n == 250)
                drain_results();
            pick    = $urandom_range(0, 99);
            add_pct = (n >= 200 && n < 300) ? 85 : 50;
            row     = $urandom_range(0, PIX_MAX);
            col     = $urandom_range(0, PIX_MAX);
            pick_shape(px, py, sa, sb);
            if (pick < add_pct)
                op = ADD_OPS[$urandom_range(0, 3)];
            else if (pick < 96) begin
                op = OP_QUERY;
                // Half the queries aim just around a stored shape so edges get hit.
                tab = t_tab'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 1 && board.fill[tab] != 0) begin
                    e = board.shapes[tab][$urandom_range(0, board.fill[tab] - 1)];
                    if (tab == TAB_REC || tab == TAB_SQU) begin
                        h = (tab == TAB_SQU) ? e.sa : e.sb;
                        r = int'(e.py) - 2 + int'($urandom_range(0, h + 4));
                        c = int'(e.px) - 2 + int'($urandom_range(0, e.sa + 4));
                    end else begin
                        h = (tab == TAB_CIR) ? e.sa : e.sb;
                        r = int'(e.py) - h - 2 + int'($urandom_range(0, 2 * h + 4));
                        c = int'(e.px) - int'(e.sa) - 2
                            + int'($urandom_range(0, 2 * int'(e.sa) + 4));
                    end
                    if (r >= 0 && r <= PIX_MAX)
                        row = r;
                    if (c >= 0 && c <= PIX_MAX)
                        col = c;
                end
            end else
                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            send_item(op, px, py, sa, sb, row, col);
        end

        // Fill every table to capacity and push two more adds into each, which must be
        // dropped and flagged. Then query a few pixels against the full scene.
        idling_on = 1'b0;
        for (int t = 0; t < 4; t++) begin
            repeat (SHAPE_CAP - board.fill[t] + 2) begin
                pick_shape(px, py, sa, sb);
                send_item(ADD_OPS[t], px, py, sa, sb, $urandom_range(0, PIX_MAX),
                          $urandom_range(0, PIX_MAX));
            end
        end
        repeat (20) begin
            pick_shape(px, py, sa, sb);
            send_item(OP_QUERY, px, py, sa, sb, $urandom_range(0, PIX_MAX),
                      $urandom_range(0, PIX_MAX));
        end

        drain_results();
        // Allow ample settling for any stray output.
        repeat (20) @(posedge i_clk);

        $display("Queries: %0d (magenta %0d, blue %0d, green %0d, red %0d, black %0d).",
                 board.queries, board.n_magenta, board.n_blue, board.n_green, board.n_red,
                 board.n_black);
        $display("Final fill sq/rect/circ/ell %0d/%0d/%0d/%0d, %0d adds dropped as full.",
                 board.fill[TAB_SQU], board.fill[TAB_REC], board.fill[TAB_CIR],
                 board.fill[TAB_ELL], board.dropped_adds);
        if (board.bad_count == 0 && board.awaited.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
